[src/stb_pkg.sv]
// Shared types, constants and request/result formats for the source byte tokenizer.
package stb_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;

    localparam int IQ_PTR_BITS = 1;
    localparam int IQ_DEPTH    = 2 ** IQ_PTR_BITS;
    localparam int OQ_PTR_BITS = 2;
    localparam int OQ_DEPTH    = 2 ** OQ_PTR_BITS;

    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_NL     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_DIG_LO = 8'h30;
    localparam logic [7:0] CHAR_DIG_HI = 8'h39;
    localparam logic [7:0] CHAR_UC_LO  = 8'h41;
    localparam logic [7:0] CHAR_UC_HI  = 8'h5A;
    localparam logic [7:0] CHAR_LC_LO  = 8'h61;
    localparam logic [7:0] CHAR_LC_HI  = 8'h7A;

    typedef enum logic [3:0] {
        KIND_END       = 4'd0,
        KIND_WORD      = 4'd1,
        KIND_NUMBER    = 4'd2,
        KIND_LPAREN    = 4'd3,
        KIND_RPAREN    = 4'd4,
        KIND_LBRACE    = 4'd5,
        KIND_RBRACE    = 4'd6,
        KIND_LBRACK    = 4'd7,
        KIND_RBRACK    = 4'd8,
        KIND_COMMA     = 4'd9,
        KIND_COLON     = 4'd10,
        KIND_SEMICOLON = 4'd11,
        KIND_EQUALS    = 4'd12
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_INVALID    = 2'd1,
        ERR_LETTER_NUM = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_NEWLINE,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_UNDER,
        CLS_HASH,
        CLS_PUNCT,
        CLS_INVALID
    } t_cls;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_byte;
    } t_in_req;

    typedef struct packed {
        logic  is_end;
        t_cls  cls;
        t_kind punct;
    } t_cls_req;

    typedef struct packed {
        t_kind                  kind;
        t_err                   error_code;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   line_number;
        logic [OFFSET_BITS-1:0] column_number;
        logic                   last_of_run;
    } t_out_tok;

endpackage

[src/stb_front.sv]
// Front end: accepts requests, classifies each byte and queues it for the lexer.
module stb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  stb_pkg::t_in_req  i_req,
    output logic              o_valid,
    output stb_pkg::t_cls_req o_cls,
    input  logic              i_pop
);
    import stb_pkg::*;

    t_cls_req               r_q [IQ_DEPTH];
    logic [IQ_PTR_BITS-1:0] r_wr_ptr;
    logic [IQ_PTR_BITS-1:0] r_rd_ptr;
    logic [IQ_PTR_BITS:0]   r_count;
    logic                   wr_en;
    logic                   rd_en;
    t_cls_req               cls_req;

    function automatic t_cls_req classify(input t_in_req req);
        t_cls_req   res;
        logic [7:0] c;
        c         = req.char_byte;
        res.is_end = req.cmd;
        res.punct  = KIND_END;
        res.cls    = CLS_INVALID;
        if (c == CHAR_NL) begin
            res.cls = CLS_NEWLINE;
        end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            res.cls = CLS_SPACE;
        end else if ((c >= CHAR_UC_LO && c <= CHAR_UC_HI) ||
                     (c >= CHAR_LC_LO && c <= CHAR_LC_HI)) begin
            res.cls = CLS_LETTER;
        end else if (c >= CHAR_DIG_LO && c <= CHAR_DIG_HI) begin
            res.cls = CLS_DIGIT;
        end else if (c == CHAR_UNDER) begin
            res.cls = CLS_UNDER;
        end else if (c == CHAR_HASH) begin
            res.cls = CLS_HASH;
        end else begin
            res.cls = CLS_PUNCT;
            case (c)
                CHAR_LPAREN: res.punct = KIND_LPAREN;
                CHAR_RPAREN: res.punct = KIND_RPAREN;
                CHAR_LBRACE: res.punct = KIND_LBRACE;
                CHAR_RBRACE: res.punct = KIND_RBRACE;
                CHAR_LBRACK: res.punct = KIND_LBRACK;
                CHAR_RBRACK: res.punct = KIND_RBRACK;
                CHAR_COMMA:  res.punct = KIND_COMMA;
                CHAR_COLON:  res.punct = KIND_COLON;
                CHAR_SEMI:   res.punct = KIND_SEMICOLON;
                CHAR_EQUALS: res.punct = KIND_EQUALS;
                default:     res.cls   = CLS_INVALID;
            endcase
        end
        return res;
    endfunction

    assign cls_req = classify(i_req);
    assign full    = (r_count == (IQ_PTR_BITS+1)'(IQ_DEPTH));
    assign wr_en   = push && !full;
    assign o_valid = (r_count != '0);
    assign rd_en   = i_pop && o_valid;
    assign o_cls   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cls_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/stb_back.sv]
// Back end: lexer state machine that turns classified bytes into tokens.
module stb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  stb_pkg::t_cls_req i_cls,
    output logic              o_pop,
    input  logic              i_oq_full,
    output logic              o_wr_en,
    output stb_pkg::t_out_tok o_wr_data
);
    import stb_pkg::*;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_WORD    = 5'b00010,
        MODE_NUM     = 5'b00100,
        MODE_COMMENT = 5'b01000,
        MODE_ERROR   = 5'b10000
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_byte_offset, n_byte_offset;
    logic [LINE_BITS-1:0]   r_line_count, n_line_count;
    logic [OFFSET_BITS-1:0] r_line_start, n_line_start;
    logic [OFFSET_BITS-1:0] r_token_start, n_token_start;
    logic [LINE_BITS-1:0]   r_token_line, n_token_line;
    logic [OFFSET_BITS-1:0] r_token_column, n_token_column;
    logic                   r_second_vld, n_second_vld;
    t_out_tok               r_second;

    logic [OFFSET_BITS-1:0] col_diff;
    logic [OFFSET_BITS-1:0] col;
    logic [OFFSET_BITS-1:0] off_inc;
    logic [LINE_BITS-1:0]   line_inc;
    logic [OFFSET_BITS-1:0] flush_len;
    t_out_tok               flush_tok;
    t_out_tok               end_tok;

    logic     idle_emit;
    t_out_tok idle_tok;
    t_mode    idle_mode;
    logic     idle_set;
    logic     idle_nl;

    logic     use_idle;
    logic     pre;
    logic     do_nl;
    logic [1:0] cnt;
    t_out_tok res0;
    t_out_tok res1;
    logic     wr_first;

    function automatic t_out_tok mk_tok(input t_kind k, input t_err e,
                                        input logic [OFFSET_BITS-1:0] start,
                                        input logic [OFFSET_BITS-1:0] len,
                                        input logic [LINE_BITS-1:0] line,
                                        input logic [OFFSET_BITS-1:0] column);
        t_out_tok t;
        t.kind          = k;
        t.error_code    = e;
        t.start_offset  = start;
        t.token_length  = len;
        t.line_number   = line;
        t.column_number = column;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    assign col_diff  = (r_byte_offset >= r_line_start) ? r_byte_offset - r_line_start : '0;
    assign col       = (col_diff == OFF_MAX) ? col_diff : col_diff + OFF_ONE;
    assign off_inc   = (r_byte_offset == OFF_MAX) ? r_byte_offset : r_byte_offset + OFF_ONE;
    assign line_inc  = (r_line_count == LINE_MAX) ? r_line_count : r_line_count + LINE_ONE;
    assign flush_len = (r_byte_offset >= r_token_start) ? r_byte_offset - r_token_start : '0;
    assign flush_tok = mk_tok((r_mode == MODE_WORD) ? KIND_WORD : KIND_NUMBER, ERR_NONE,
                              r_token_start, flush_len, r_token_line, r_token_column);
    assign end_tok   = mk_tok(KIND_END, ERR_NONE, r_byte_offset, '0, r_line_count, OFF_ONE);

    assign o_pop = i_valid && !r_second_vld && !i_oq_full;

    always_comb begin
        idle_emit = 1'b0;
        idle_tok  = end_tok;
        idle_mode = MODE_IDLE;
        idle_set  = 1'b0;
        idle_nl   = 1'b0;
        case (i_cls.cls)
            CLS_SPACE: begin
                idle_nl = 1'b0;
            end
            CLS_NEWLINE: begin
                idle_nl = 1'b1;
            end
            CLS_LETTER, CLS_UNDER: begin
                idle_mode = MODE_WORD;
                idle_set  = 1'b1;
            end
            CLS_DIGIT: begin
                idle_mode = MODE_NUM;
                idle_set  = 1'b1;
            end
            CLS_HASH: begin
                idle_mode = MODE_COMMENT;
            end
            CLS_PUNCT: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(i_cls.punct, ERR_NONE, r_byte_offset, OFF_ONE,
                                   r_line_count, col);
            end
            default: begin
                idle_emit = 1'b1;
                idle_tok  = mk_tok(KIND_END, ERR_INVALID, r_byte_offset, '0, r_line_count, col);
                idle_mode = MODE_ERROR;
            end
        endcase
    end

    always_comb begin
        n_mode         = r_mode;
        n_byte_offset  = r_byte_offset;
        n_line_count   = r_line_count;
        n_line_start   = r_line_start;
        n_token_start  = r_token_start;
        n_token_line   = r_token_line;
        n_token_column = r_token_column;
        use_idle       = 1'b0;
        pre            = 1'b0;
        do_nl          = 1'b0;
        cnt            = 2'd0;
        res0           = end_tok;
        res1           = end_tok;
        if (o_pop) begin
            if (i_cls.is_end) begin
                if (r_mode == MODE_WORD || r_mode == MODE_NUM) begin
                    res0 = flush_tok;
                    res1 = end_tok;
                    cnt  = 2'd2;
                end else if (r_mode != MODE_ERROR) begin
                    res0 = end_tok;
                    cnt  = 2'd1;
                end
                n_mode         = MODE_IDLE;
                n_byte_offset  = '0;
                n_line_count   = LINE_ONE;
                n_line_start   = '0;
                n_token_start  = '0;
                n_token_line   = LINE_ONE;
                n_token_column = OFF_ONE;
            end else begin
                n_byte_offset = off_inc;
                case (r_mode)
                    MODE_ERROR: begin
                        n_mode = MODE_ERROR;
                    end
                    MODE_COMMENT: begin
                        if (i_cls.cls == CLS_NEWLINE) begin
                            do_nl  = 1'b1;
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_WORD: begin
                        if (!(i_cls.cls == CLS_LETTER || i_cls.cls == CLS_DIGIT ||
                              i_cls.cls == CLS_UNDER)) begin
                            res0     = flush_tok;
                            pre      = 1'b1;
                            use_idle = 1'b1;
                        end
                    end
                    MODE_NUM: begin
                        if (i_cls.cls == CLS_LETTER) begin
                            res0   = mk_tok(KIND_END, ERR_LETTER_NUM, r_byte_offset, '0,
                                            r_line_count, col);
                            cnt    = 2'd1;
                            n_mode = MODE_ERROR;
                        end else if (i_cls.cls != CLS_DIGIT) begin
                            res0     = flush_tok;
                            pre      = 1'b1;
                            use_idle = 1'b1;
                        end
                    end
                    default: begin
                        use_idle = 1'b1;
                    end
                endcase
                if (use_idle) begin
                    n_mode = idle_mode;
                    do_nl  = idle_nl;
                    if (idle_set) begin
                        n_token_start  = r_byte_offset;
                        n_token_line   = r_line_count;
                        n_token_column = col;
                    end
                    if (idle_emit && pre) begin
                        res1 = idle_tok;
                        cnt  = 2'd2;
                    end else if (idle_emit) begin
                        res0 = idle_tok;
                        cnt  = 2'd1;
                    end else begin
                        cnt = pre ? 2'd1 : 2'd0;
                    end
                end
                if (do_nl) begin
                    n_line_count = line_inc;
                    n_line_start = off_inc;
                end
            end
        end
        res0.last_of_run = (cnt == 2'd1);
        res1.last_of_run = 1'b1;
    end

    assign wr_first  = o_pop && (cnt != 2'd0);
    assign o_wr_en   = r_second_vld ? !i_oq_full : wr_first;
    assign o_wr_data = r_second_vld ? r_second : res0;

    always_comb begin
        n_second_vld = r_second_vld;
        if (r_second_vld && !i_oq_full) begin
            n_second_vld = 1'b0;
        end else if (o_pop && cnt == 2'd2) begin
            n_second_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && cnt == 2'd2) begin
            r_second <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_byte_offset  <= '0;
            r_line_count   <= LINE_ONE;
            r_line_start   <= '0;
            r_token_start  <= '0;
            r_token_line   <= LINE_ONE;
            r_token_column <= OFF_ONE;
            r_second_vld   <= 1'b0;
        end else begin
            r_mode         <= n_mode;
            r_byte_offset  <= n_byte_offset;
            r_line_count   <= n_line_count;
            r_line_start   <= n_line_start;
            r_token_start  <= n_token_start;
            r_token_line   <= n_token_line;
            r_token_column <= n_token_column;
            r_second_vld   <= n_second_vld;
        end
    end

endmodule

[src/stb_out_queue.sv]
// Result queue between the lexer and the result ports.
module stb_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  stb_pkg::t_out_tok i_wr_data,
    output logic              o_full,
    output logic              empty,
    input  logic              pop,
    output stb_pkg::t_out_tok o_result
);
    import stb_pkg::*;

    t_out_tok               r_q [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0] r_wr_ptr;
    logic [OQ_PTR_BITS-1:0] r_rd_ptr;
    logic [OQ_PTR_BITS:0]   r_count;
    logic                   wr_en;
    logic                   rd_en;

    assign o_full   = (r_count == (OQ_PTR_BITS+1)'(OQ_DEPTH));
    assign empty    = (r_count == '0);
    assign wr_en    = i_wr_en && !o_full;
    assign rd_en    = pop && !empty;
    assign o_result = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/source_byte_tokenizer.sv]
// Top level of the source byte tokenizer: classifier front end, lexer back end, result queue.
// Each request is registered in the input queue; the lexer's results are registered in the result queue.
// Throughput: one request per cycle while the result queue has room; a request that yields two results
// holds the lexer while it writes the second result into the four-entry result queue.
// Reset (synchronous, active low) empties both queues and returns the lexer to idle, offset 0, line 1.
module source_byte_tokenizer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  stb_pkg::t_in_req  i_req,
    output logic              empty,
    input  logic              pop,
    output stb_pkg::t_out_tok o_result
);
    import stb_pkg::*;

    logic     cls_valid;
    t_cls_req cls_req;
    logic     cls_pop;
    logic     oq_full;
    logic     oq_wr_en;
    t_out_tok oq_wr_data;

    stb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .o_valid (cls_valid),
        .o_cls   (cls_req),
        .i_pop   (cls_pop)
    );

    stb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (cls_valid),
        .i_cls     (cls_req),
        .o_pop     (cls_pop),
        .i_oq_full (oq_full),
        .o_wr_en   (oq_wr_en),
        .o_wr_data (oq_wr_data)
    );

    stb_out_queue u_out_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (oq_wr_en),
        .i_wr_data (oq_wr_data),
        .o_full    (oq_full),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

endmodule

[src/stb_checker.sv]
// Port-level checker for the source byte tokenizer, bound to the top level.
module stb_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input stb_pkg::t_out_tok o_result
);
    import stb_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or dropped");

    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind == KIND_END && o_result.error_code == ERR_NONE) |->
        (o_result.column_number == OFFSET_BITS'(1) && o_result.token_length == '0 &&
         o_result.last_of_run))
        else $error("malformed end token");

    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error_code != ERR_NONE) |->
        (o_result.kind == KIND_END && o_result.token_length == '0 && o_result.last_of_run))
        else $error("malformed error result");

    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.kind != KIND_END && o_result.kind != KIND_WORD &&
         o_result.kind != KIND_NUMBER) |->
        (o_result.token_length == OFFSET_BITS'(1) && o_result.line_number != '0))
        else $error("punctuation token length or line wrong");

endmodule

bind source_byte_tokenizer stb_checker u_stb_checker (.*);

[tb/sv/tb_source_byte_tokenizer.sv]
// Self-checking testbench for the source byte tokenizer: directed and random source text.
`timescale 1ns / 100ps

module tb_source_byte_tokenizer;
    import stb_pkg::*;

    localparam int SEND_TARGET  = 1200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_COMMENT,
        SCAN_ERROR
    } t_scan;

    class token_scoreboard;
        t_out_tok               expected_q[$];
        int                     mismatches;
        int                     produced;
        t_scan                  scan;
        logic [OFFSET_BITS-1:0] offset;
        logic [OFFSET_BITS-1:0] line_start;
        logic [OFFSET_BITS-1:0] tok_start;
        logic [OFFSET_BITS-1:0] tok_column;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   tok_line;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            scan       = SCAN_IDLE;
            offset     = '0;
            line       = LINE_BITS'(1);
            line_start = '0;
            tok_start  = '0;
            tok_line   = LINE_BITS'(1);
            tok_column = OFFSET_BITS'(1);
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= CHAR_UC_LO && c <= CHAR_UC_HI) || (c >= CHAR_LC_LO && c <= CHAR_LC_HI);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CHAR_DIG_LO && c <= CHAR_DIG_HI;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
        endfunction

        function logic [OFFSET_BITS-1:0] bump_ofs(logic [OFFSET_BITS-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function logic [LINE_BITS-1:0] bump_line(logic [LINE_BITS-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function logic [OFFSET_BITS-1:0] column_now();
            logic [OFFSET_BITS-1:0] d;
            d = (offset >= line_start) ? offset - line_start : '0;
            return bump_ofs(d);
        endfunction

        function t_kind punct_kind(logic [7:0] c);
            case (c)
                CHAR_LPAREN: return KIND_LPAREN;
                CHAR_RPAREN: return KIND_RPAREN;
                CHAR_LBRACE: return KIND_LBRACE;
                CHAR_RBRACE: return KIND_RBRACE;
                CHAR_LBRACK: return KIND_LBRACK;
                CHAR_RBRACK: return KIND_RBRACK;
                CHAR_COMMA:  return KIND_COMMA;
                CHAR_COLON:  return KIND_COLON;
                CHAR_SEMI:   return KIND_SEMICOLON;
                CHAR_EQUALS: return KIND_EQUALS;
                default:     return KIND_END;
            endcase
        endfunction

        function void add_tok(t_kind k, t_err e, logic [OFFSET_BITS-1:0] st,
                              logic [OFFSET_BITS-1:0] len, logic [LINE_BITS-1:0] ln,
                              logic [OFFSET_BITS-1:0] col);
            t_out_tok t;
            if (produced >= 2) return;
            t.kind          = k;
            t.error_code    = e;
            t.start_offset  = st;
            t.token_length  = len;
            t.line_number   = ln;
            t.column_number = col;
            t.last_of_run   = 1'b0;
            expected_q.insert(expected_q.size(), t);
            produced++;
        endfunction

        function void next_line();
            line       = bump_line(line);
            line_start = bump_ofs(offset);
        endfunction

        function void flush_token();
            t_kind k;
            if (scan == SCAN_WORD) begin
                k = KIND_WORD;
            end else begin
                k = KIND_NUMBER;
            end
            add_tok(k, ERR_NONE, tok_start, (offset >= tok_start) ? offset - tok_start : '0,
                    tok_line, tok_column);
            scan = SCAN_IDLE;
        endfunction

        function void start_byte(logic [7:0] c);
            logic [OFFSET_BITS-1:0] col;
            t_kind                  pk;
            col = column_now();
            pk  = punct_kind(c);
            if (is_space(c)) begin
                if (c == CHAR_NL) next_line();
            end else if (is_letter(c) || c == CHAR_UNDER || is_digit(c)) begin
                if (is_digit(c)) begin
                    scan = SCAN_NUMBER;
                end else begin
                    scan = SCAN_WORD;
                end
                tok_start  = offset;
                tok_line   = line;
                tok_column = col;
            end else if (c == CHAR_HASH) begin
                scan = SCAN_COMMENT;
            end else if (pk != KIND_END) begin
                add_tok(pk, ERR_NONE, offset, OFFSET_BITS'(1), line, col);
            end else begin
                add_tok(KIND_END, ERR_INVALID, offset, '0, line, col);
                scan = SCAN_ERROR;
            end
        endfunction

        function void note_request(t_in_req r);
            logic [7:0] c;
            c        = r.char_byte;
            produced = 0;
            if (r.cmd) begin
                if (scan == SCAN_ERROR) begin
                    clear();
                    return;
                end
                if (scan == SCAN_WORD || scan == SCAN_NUMBER) flush_token();
                add_tok(KIND_END, ERR_NONE, offset, '0, line, OFFSET_BITS'(1));
                clear();
            end else begin
                case (scan)
                    SCAN_ERROR: ;
                    SCAN_COMMENT: begin
                        if (c == CHAR_NL) begin
                            next_line();
                            scan = SCAN_IDLE;
                        end
                    end
                    SCAN_WORD: begin
                        if (!(is_letter(c) || is_digit(c) || c == CHAR_UNDER)) begin
                            flush_token();
                            start_byte(c);
                        end
                    end
                    SCAN_NUMBER: begin
                        if (is_letter(c)) begin
                            add_tok(KIND_END, ERR_LETTER_NUM, offset, '0, line, column_now());
                            scan = SCAN_ERROR;
                        end else if (!is_digit(c)) begin
                            flush_token();
                            start_byte(c);
                        end
                    end
                    default: begin
                        scan = SCAN_IDLE;
                        start_byte(c);
                    end
                endcase
                offset = bump_ofs(offset);
            end
            if (produced > 0) begin
                expected_q[expected_q.size() - 1].last_of_run = 1'b1;
            end
        endfunction

        function string show(t_out_tok t);
            return $sformatf("kind=%0d err=%0d start=%0d len=%0d line=%0d col=%0d last=%0b",
                             t.kind, t.error_code, t.start_offset, t.token_length,
                             t.line_number, t.column_number, t.last_of_run);
        endfunction

        function void check_result(t_out_tok got);
            t_out_tok want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %s", show(got));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.error_code !== want.error_code ||
                got.start_offset !== want.start_offset ||
                got.token_length !== want.token_length ||
                got.line_number !== want.line_number ||
                got.column_number !== want.column_number ||
                got.last_of_run !== want.last_of_run) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %s", show(want));
                    $display("          actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     full;
    t_in_req  i_req   = '0;
    logic     empty;
    logic     pop     = 1'b0;
    t_out_tok o_result;

    int  send_idle_pct = 21;
    int  recv_idle_pct = 71;
    int  items_sent    = 0;
    int  cycles        = 0;
    bit  prev_alnum    = 1'b0;

    token_scoreboard sb = new();

    source_byte_tokenizer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_req    (i_req),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (pop && !empty) sb.check_result(o_result);
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_req(t_in_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (full);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] c);
        t_in_req r;
        r.cmd       = 1'b0;
        r.char_byte = c;
        send_req(r);
    endtask

    task automatic send_end();
        t_in_req r;
        r.cmd       = 1'b1;
        r.char_byte = 8'($urandom);
        send_req(r);
        prev_alnum = 1'b0;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_letter();
        if ($urandom_range(1) == 1) return CHAR_UC_LO + 8'($urandom_range(25));
        return CHAR_LC_LO + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_DIG_LO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] pick_ident();
        case ($urandom_range(3))
            0:       return pick_digit();
            1:       return CHAR_UNDER;
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        if ($urandom_range(3) == 0) return CHAR_SPACE;
        return CHAR_TAB + 8'($urandom_range(4));
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(9))
            0:       return CHAR_LPAREN;
            1:       return CHAR_RPAREN;
            2:       return CHAR_LBRACE;
            3:       return CHAR_RBRACE;
            4:       return CHAR_LBRACK;
            5:       return CHAR_RBRACK;
            6:       return CHAR_COMMA;
            7:       return CHAR_COLON;
            8:       return CHAR_SEMI;
            default: return CHAR_EQUALS;
        endcase
    endfunction

    task automatic send_token();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 52 && prev_alnum) send_byte(pick_space());
        prev_alnum = 1'b0;
        if (pick < 32) begin
            send_byte(($urandom_range(3) == 0) ? CHAR_UNDER : pick_letter());
            repeat ($urandom_range(7)) send_byte(pick_ident());
            prev_alnum = 1'b1;
        end else if (pick < 52) begin
            repeat ($urandom_range(1, 6)) send_byte(pick_digit());
            prev_alnum = 1'b1;
        end else if (pick < 72) begin
            send_byte(pick_punct());
        end else if (pick < 88) begin
            send_byte(pick_space());
        end else if (pick < 96) begin
            send_byte(CHAR_HASH);
            repeat ($urandom_range(8)) begin
                c = 8'($urandom);
                if (c == CHAR_NL) c = CHAR_SPACE;
                send_byte(c);
            end
            if ($urandom_range(3) != 0) send_byte(CHAR_NL);
        end else if (pick < 98) begin
            send_byte(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(pick_digit());
            send_byte(pick_letter());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_text("a_9(1){}[],:;=\t#x\n7_");
        send_byte(8'h80);
        send_end();
        send_text("5q");
        send_byte(8'hFF);
        send_end();
        send_text("#c");
        send_end();

        while (items_sent < SEND_TARGET) begin
            if (items_sent >= 2 * SEND_TARGET / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent >= SEND_TARGET / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 21;
            end
            repeat ($urandom_range(1, 30)) send_token();
            send_end();
        end
        push <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
